// ===== sv/tes_pkg.sv =====
// Shared types and constants for the timing event scheduler.
package tes_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_ADVANCE    = 2'd0;
  localparam logic [1:0] REQ_ACTIVATE   = 2'd1;
  localparam logic [1:0] REQ_DEACTIVATE = 2'd2;

  localparam logic signed [31:0] DC_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] DC_MIN = 32'sh8000_0000;
  localparam logic [30:0]        U31_MAX = 31'h7FFF_FFFF;

  // One input item
  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         slot;
    logic [23:0]        elapsed_ticks;
    logic signed [31:0] start_downcount;
    logic [30:0]        reload_interval;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic               fired;
    logic [3:0]         fired_slot;
    logic [30:0]        exec_ticks;
    logic [30:0]        late_ticks;
    logic signed [31:0] next_downcount;
    logic               none_active;
    logic               last;
  } out_item_t;

  // One entry of the slot memory
  typedef struct packed {
    logic signed [31:0] dc;
    logic [30:0]        iv;
    logic [30:0]        el;
  } slot_word_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_PASS,
    ST_DECIDE
  } tes_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture the accepted item
    logic apply;      // activate / deactivate, clear pending firing
    logic clr_best;   // restart the minimum search
    logic rd;         // read slot memory at rd_addr
    logic upd;        // this pass subtracts elapsed ticks
    logic fire;       // commit a firing of the best slot
    logic emit_final; // send the last result of the item
  } tes_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_adv;     // current item is an advance
    logic fire_ok;    // a minimum exists and is due
  } tes_sts_t;

endpackage

// ===== sv/tes_datapath.sv =====
// Slot memory, active flags, minimum search, firing arithmetic and result register.
module tes_datapath #(
  parameter int NUM_SLOTS = 16,
  parameter int AW        = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tes_pkg::in_item_t   in_item,
  input  tes_pkg::tes_cmd_t   cmd,
  input  logic [AW-1:0]       rd_addr,
  output tes_pkg::tes_sts_t   sts,
  output logic                out_valid,
  output tes_pkg::out_item_t  out_item
);
  import tes_pkg::*;

  in_item_t           req_r;
  logic [NUM_SLOTS-1:0] act_r;
  slot_word_t         mem_r [NUM_SLOTS];
  slot_word_t         rd_q_r;
  logic               rd_vld_r;
  logic [AW-1:0]      rd_idx_r;

  logic               best_vld_r;
  logic [AW-1:0]      best_idx_r;
  logic signed [31:0] best_dc_r;
  logic [30:0]        best_el_r;
  logic [30:0]        best_iv_r;

  logic               pend_vld_r;
  logic [3:0]         pend_slot_r;
  logic [30:0]        pend_tte_r;
  logic [30:0]        pend_late_r;

  logic               out_valid_r;
  out_item_t          out_item_r;

  logic [6:0]         slot_ext;
  logic [AW-1:0]      slot_addr;
  logic               slot_ok;
  logic [6:0]         best_ext;
  logic signed [32:0] sub33;
  logic [31:0]        el32;
  logic signed [31:0] cur_dc;
  logic [30:0]        cur_el;
  logic               cur_act;
  logic signed [32:0] rel33;
  logic signed [31:0] dc_reload;
  logic [32:0]        late33;
  logic [30:0]        late31;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  slot_word_t         wr_data;
  logic signed [31:0] next_dc;

  // Request slot decode
  assign slot_ext  = 7'(req_r.slot);
  assign slot_addr = slot_ext[AW-1:0];
  assign slot_ok   = slot_ext < 7'(NUM_SLOTS);
  assign best_ext  = 7'(best_idx_r);

  // Advance arithmetic on the slot just read, with saturation
  always_comb begin
    sub33   = {rd_q_r.dc[31], rd_q_r.dc} - $signed({9'd0, req_r.elapsed_ticks});
    el32    = {1'b0, rd_q_r.el} + {8'd0, req_r.elapsed_ticks};
    cur_act = act_r[rd_idx_r];
    if (cmd.upd && cur_act) begin
      cur_dc = (sub33[32] != sub33[31]) ? DC_MIN : sub33[31:0];
      cur_el = el32[31] ? U31_MAX : el32[30:0];
    end else begin
      cur_dc = rd_q_r.dc;
      cur_el = rd_q_r.el;
    end
  end

  // Reload and lateness of the slot that fires
  always_comb begin
    rel33     = {best_dc_r[31], best_dc_r} + $signed({2'd0, best_iv_r});
    dc_reload = (rel33[32] != rel33[31]) ? DC_MAX : rel33[31:0];
    late33    = 33'd0 - {best_dc_r[31], best_dc_r};
    late31    = late33[31] ? U31_MAX : late33[30:0];
  end

  // Single write port of the slot memory
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx_r;
    wr_data = '{dc: cur_dc, iv: rd_q_r.iv, el: cur_el};
    priority if (cmd.apply && req_r.req_type == REQ_ACTIVATE && slot_ok) begin
      wr_en   = 1'b1;
      wr_addr = slot_addr;
      wr_data = '{dc: req_r.start_downcount, iv: req_r.reload_interval, el: '0};
    end else if (cmd.fire) begin
      wr_en   = 1'b1;
      wr_addr = best_idx_r;
      wr_data = '{dc: dc_reload, iv: best_iv_r, el: '0};
    end else if (rd_vld_r && cmd.upd && cur_act) begin
      wr_en   = 1'b1;
    end else begin
      wr_en   = 1'b0;
    end
  end

  // Slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_q_r <= mem_r[rd_addr];
    end
    rd_idx_r <= rd_addr;
  end

  // Read-data valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
    end
  end

  // Captured request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_item;
    end
  end

  // Active flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
    end else if (cmd.apply && slot_ok) begin
      if (req_r.req_type == REQ_ACTIVATE) begin
        act_r[slot_addr] <= 1'b1;
      end else if (req_r.req_type == REQ_DEACTIVATE) begin
        act_r[slot_addr] <= 1'b0;
      end
    end
  end

  // Running minimum over one pass, ties kept at the lowest slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
    end else if (cmd.clr_best) begin
      best_vld_r <= 1'b0;
    end else if (rd_vld_r && cur_act && (!best_vld_r || cur_dc < best_dc_r)) begin
      best_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r && cur_act && (!best_vld_r || cur_dc < best_dc_r)) begin
      best_idx_r <= rd_idx_r;
      best_dc_r  <= cur_dc;
      best_el_r  <= cur_el;
      best_iv_r  <= rd_q_r.iv;
    end
  end

  // Firing held back until we know whether another follows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else if (cmd.apply) begin
      pend_vld_r <= 1'b0;
    end else if (cmd.fire) begin
      pend_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      pend_slot_r <= best_ext[3:0];
      pend_tte_r  <= best_el_r;
      pend_late_r <= late31;
    end
  end

  assign next_dc = best_vld_r ? best_dc_r : '0;

  // Result register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.fire && pend_vld_r) || cmd.emit_final;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire && pend_vld_r) begin
      out_item_r <= '{fired: 1'b1, fired_slot: pend_slot_r, exec_ticks: pend_tte_r,
                      late_ticks: pend_late_r, next_downcount: '0, none_active: 1'b0,
                      last: 1'b0};
    end else if (cmd.emit_final) begin
      if (pend_vld_r) begin
        out_item_r <= '{fired: 1'b1, fired_slot: pend_slot_r, exec_ticks: pend_tte_r,
                        late_ticks: pend_late_r, next_downcount: next_dc,
                        none_active: !best_vld_r, last: 1'b1};
      end else begin
        out_item_r <= '{fired: 1'b0, fired_slot: '0, exec_ticks: '0,
                        late_ticks: '0, next_downcount: next_dc,
                        none_active: !best_vld_r, last: 1'b1};
      end
    end
  end

  assign sts.is_adv  = (req_r.req_type == REQ_ADVANCE);
  assign sts.fire_ok = best_vld_r && (best_dc_r[31] || best_dc_r == '0);
  assign out_valid   = out_valid_r;
  assign out_item    = out_item_r;

endmodule

// ===== sv/tes_ctrl.sv =====
// Sequencer for the scheduler: request apply, slot passes and firing decisions.
module tes_ctrl #(
  parameter int NUM_SLOTS   = 16,
  parameter int MAX_FIRINGS = 64,
  parameter int AW          = 4,
  parameter int CW          = 5,
  parameter int FW          = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tes_pkg::tes_sts_t   sts,
  output tes_pkg::tes_cmd_t   cmd,
  output logic [AW-1:0]       rd_addr
);
  import tes_pkg::*;

  tes_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r;
  logic [FW-1:0] nfire_r;
  logic          upd_r;
  logic          rd_more;
  logic          fire_go;

  assign rd_more = cnt_r < CW'(NUM_SLOTS);
  assign fire_go = sts.is_adv && sts.fire_ok && (nfire_r < FW'(MAX_FIRINGS));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY:  state_nxt = ST_PASS;
      ST_PASS:   if (!rd_more) begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: state_nxt = fire_go ? ST_PASS : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    cmd.upd = upd_r;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_APPLY: begin
        cmd.apply    = 1'b1;
        cmd.clr_best = 1'b1;
      end
      ST_PASS: begin
        cmd.rd = rd_more;
      end
      ST_DECIDE: begin
        cmd.fire       = fire_go;
        cmd.clr_best   = fire_go;
        cmd.emit_final = !fire_go;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign rd_addr = cnt_r[AW-1:0];

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      nfire_r <= '0;
      upd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_APPLY: begin
          cnt_r   <= '0;
          nfire_r <= '0;
          upd_r   <= sts.is_adv;
        end
        ST_PASS: begin
          if (rd_more) begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        ST_DECIDE: begin
          cnt_r <= '0;
          upd_r <= 1'b0;
          if (fire_go) begin
            nfire_r <= nfire_r + FW'(1);
          end
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

endmodule

// ===== sv/timing_event_scheduler.sv =====
// Top level of the timing event scheduler: controller plus slot datapath.
//
// Usage: drive in_item and raise start; the item is taken at a clock edge
// with start high and busy low. Advance items subtract elapsed_ticks from
// every active slot and then fire due slots, smallest downcount first, ties
// to the lowest slot, up to MAX_FIRINGS per item. Activate and deactivate
// items edit one slot and give a single status result.
// Results appear on out_item for one cycle with out_valid high; out_item.last
// marks the final result of an item, which carries the smallest remaining
// downcount. The receiver cannot stall; every result must be taken.
// One slot pass walks the slot memory through its single read port. Each
// firing of an advance adds a pass and a decision before its result;
// busy stays high until the last result is issued. The next item may be
// accepted while the last result is on the outputs.
// Reset (synchronous, rst_n low) clears all active flags and the sequencer;
// slot contents are loaded by activation.
module timing_event_scheduler #(
  parameter int NUM_SLOTS   = 16,
  parameter int MAX_FIRINGS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tes_pkg::in_item_t  in_item,
  output logic               out_valid,
  output tes_pkg::out_item_t out_item
);
  import tes_pkg::*;

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int FW = $clog2(MAX_FIRINGS + 1);

  tes_cmd_t      cmd;
  tes_sts_t      sts;
  logic [AW-1:0] rd_addr;

  // Sequencer
  tes_ctrl #(
    .NUM_SLOTS   (NUM_SLOTS),
    .MAX_FIRINGS (MAX_FIRINGS),
    .AW          (AW),
    .CW          (CW),
    .FW          (FW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .sts     (sts),
    .cmd     (cmd),
    .rd_addr (rd_addr)
  );

  // Slot storage and arithmetic
  tes_datapath #(
    .NUM_SLOTS (NUM_SLOTS),
    .AW        (AW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for timing_event_scheduler, with its own slot-table scheduler model.
module tb_top;
  import tes_pkg::*;

  localparam int NUM_SLOTS   = 16;
  localparam int MAX_FIRINGS = 64;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  timing_event_scheduler #(
    .NUM_SLOTS   (NUM_SLOTS),
    .MAX_FIRINGS (MAX_FIRINGS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Commands waiting to be sent, and firing reports still owed by the block
  in_item_t  sched_cmds[$];
  out_item_t owed_reports[$];

  // Slot table as the scheduler should hold it
  logic               slot_live   [NUM_SLOTS];
  logic signed [31:0] slot_count  [NUM_SLOTS];
  logic [30:0]        slot_reload [NUM_SLOTS];
  logic [30:0]        slot_age    [NUM_SLOTS];
  longint unsigned    tick_total;

  int mismatches    = 0;
  int cmds_taken    = 0;
  int advances      = 0;
  int cap_hits      = 0;
  int clip_hits     = 0;
  int reports_seen  = 0;
  int firings_seen  = 0;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) slot_live[i] = 1'b0;
    tick_total = 0;
  end

  function automatic logic signed [31:0] clip_count(longint v);
    if (v > longint'(DC_MAX)) return DC_MAX;
    if (v < longint'(DC_MIN)) return DC_MIN;
    return v[31:0];
  endfunction

  // Live slot with the smallest downcount, lowest index on a tie; -1 if none
  function automatic int earliest_due_slot();
    int best;
    best = -1;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_live[i] && (best < 0 || slot_count[i] < slot_count[best])) best = i;
    return best;
  endfunction

  // Apply one command to the slot table and queue the reports it should give
  function automatic void advance_scheduler(in_item_t cmd);
    out_item_t rep;
    out_item_t held;
    bit        have_held;
    bit        done;
    int        n_fire;
    int        best;
    longint    acc;
    n_fire    = 0;
    have_held = 1'b0;
    held      = '0;
    case (cmd.req_type)
      REQ_ACTIVATE: begin
        slot_live[cmd.slot]   = 1'b1;
        slot_count[cmd.slot]  = cmd.start_downcount;
        slot_reload[cmd.slot] = cmd.reload_interval;
        slot_age[cmd.slot]    = '0;
      end
      REQ_DEACTIVATE: slot_live[cmd.slot] = 1'b0;
      REQ_ADVANCE: begin
        advances++;
        tick_total += cmd.elapsed_ticks;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_live[i]) begin
            slot_count[i] = clip_count(longint'(slot_count[i]) - longint'(cmd.elapsed_ticks));
            acc = longint'(slot_age[i]) + longint'(cmd.elapsed_ticks);
            slot_age[i] = (acc > longint'(U31_MAX)) ? U31_MAX : acc[30:0];
          end
        end
        // fire due slots, earliest first, up to the per-item cap
        done = 1'b0;
        while (!done && n_fire < MAX_FIRINGS) begin
          best = earliest_due_slot();
          if (best < 0 || slot_count[best] > 0) begin
            done = 1'b1;
          end else begin
            acc = -longint'(slot_count[best]);
            if (acc > longint'(U31_MAX) || slot_age[best] == U31_MAX) clip_hits++;
            rep             = '0;
            rep.fired       = 1'b1;
            rep.fired_slot  = best[3:0];
            rep.exec_ticks  = slot_age[best];
            rep.late_ticks  = (acc > longint'(U31_MAX)) ? U31_MAX : acc[30:0];
            if (have_held) owed_reports.insert(owed_reports.size(), held);
            held      = rep;
            have_held = 1'b1;
            slot_count[best] = clip_count(longint'(slot_count[best]) +
                                          longint'(slot_reload[best]));
            slot_age[best]   = '0;
            n_fire++;
          end
        end
        if (n_fire == MAX_FIRINGS) cap_hits++;
      end
      default: ;
    endcase
    // last report of the item carries the earliest remaining downcount
    best = earliest_due_slot();
    if (!have_held) held = '0;
    held.next_downcount = (best < 0) ? '0 : slot_count[best];
    held.none_active    = (best < 0);
    held.last           = 1'b1;
    owed_reports.insert(owed_reports.size(), held);
  endfunction

  // Build a command; fields the request does not use carry random bits
  function automatic in_item_t make_cmd(logic [1:0] req, int s, longint dt, longint dc,
                                        longint ivl);
    in_item_t c;
    c.req_type        = req;
    c.slot            = 4'($urandom);
    c.elapsed_ticks   = 24'($urandom);
    c.start_downcount = $urandom;
    c.reload_interval = 31'($urandom);
    case (req)
      REQ_ADVANCE: c.elapsed_ticks = dt[23:0];
      REQ_ACTIVATE: begin
        c.slot            = s[3:0];
        c.start_downcount = dc[31:0];
        c.reload_interval = ivl[30:0];
      end
      REQ_DEACTIVATE: c.slot = s[3:0];
      default: ;
    endcase
    return c;
  endfunction

  // Append one command to the send queue
  function automatic void queue_cmd(in_item_t c);
    sched_cmds.insert(sched_cmds.size(), c);
  endfunction

  // Driver: start is held until the item is taken; random gaps between items
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        advance_scheduler(in_item);
        cmds_taken++;
      end
      if (!(start && busy)) begin
        if (sched_cmds.size() != 0 &&
            ((cmds_taken >= 30 && cmds_taken < 100) || $urandom_range(0, 99) >= 30)) begin
          in_item <= sched_cmds.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string field, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Monitor: every strobed result is checked against the oldest owed report
  out_item_t want_rep;
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (owed_reports.size() == 0) begin
        $error("result with no report owed: fired %0b slot %0d", out_item.fired,
               out_item.fired_slot);
        mismatches++;
      end else begin
        want_rep = owed_reports.pop_front();
        compare_field("fired", want_rep.fired, out_item.fired);
        compare_field("fired_slot", want_rep.fired_slot, out_item.fired_slot);
        compare_field("exec_ticks", want_rep.exec_ticks, out_item.exec_ticks);
        compare_field("late_ticks", want_rep.late_ticks, out_item.late_ticks);
        compare_field("next_downcount", longint'(want_rep.next_downcount),
                      longint'(out_item.next_downcount));
        compare_field("none_active", want_rep.none_active, out_item.none_active);
        compare_field("last", want_rep.last, out_item.last);
        reports_seen++;
        if (out_item.fired) firings_seen++;
      end
    end
  end

  // Stimulus, then wait for the block to drain
  initial begin
    bit [15:0] gen_live;
    int        rand_cmds;
    int        s;
    int        n_act;
    int        n_adv;
    longint    dt;
    in_item_t  c;
    gen_live  = '0;
    rand_cmds = 0;

    // directed: empty table, reserved code, stale deactivate, extremes, ties
    queue_cmd(make_cmd(REQ_ADVANCE, 0, 0, 0, 0));
    queue_cmd(make_cmd(REQ_RESERVED, 0, 0, 0, 0));
    queue_cmd(make_cmd(REQ_DEACTIVATE, 5, 0, 0, 0));
    queue_cmd(make_cmd(REQ_ACTIVATE, 0, 0, 0, 1));
    queue_cmd(make_cmd(REQ_ACTIVATE, 15, 0, longint'(DC_MIN), longint'(U31_MAX)));
    queue_cmd(make_cmd(REQ_ACTIVATE, 7, 0, longint'(DC_MAX), 100));
    queue_cmd(make_cmd(REQ_ACTIVATE, 3, 0, 0, 50));
    queue_cmd(make_cmd(REQ_ADVANCE, 0, 0, 0, 0));
    // huge step with short intervals: cap reached, backlog carried over
    queue_cmd(make_cmd(REQ_ADVANCE, 0, 24'hFF_FFFF, 0, 0));
    queue_cmd(make_cmd(REQ_ADVANCE, 0, 0, 0, 0));
    // re-arm a live slot with a zero interval
    queue_cmd(make_cmd(REQ_ACTIVATE, 0, 0, -5, 0));
    queue_cmd(make_cmd(REQ_ADVANCE, 0, 1, 0, 0));
    queue_cmd(make_cmd(REQ_DEACTIVATE, 0, 0, 0, 0));
    queue_cmd(make_cmd(REQ_DEACTIVATE, 3, 0, 0, 0));
    // downcount underflow saturates
    queue_cmd(make_cmd(REQ_ACTIVATE, 9, 0, longint'(DC_MIN) + 10, 5));
    queue_cmd(make_cmd(REQ_ADVANCE, 0, 24'hFF_FFFF, 0, 0));
    queue_cmd(make_cmd(REQ_DEACTIVATE, 9, 0, 0, 0));
    queue_cmd(make_cmd(REQ_DEACTIVATE, 15, 0, 0, 0));
    queue_cmd(make_cmd(REQ_DEACTIVATE, 7, 0, 0, 0));
    queue_cmd(make_cmd(REQ_ADVANCE, 0, 12345, 0, 0));

    // long soak on one slot so its elapsed time saturates before it fires
    for (int i = 0; i < NUM_SLOTS; i++)
      queue_cmd(make_cmd(REQ_DEACTIVATE, i, 0, 0, 0));
    queue_cmd(make_cmd(REQ_ACTIVATE, 4, 0, longint'(DC_MAX), longint'(U31_MAX)));
    for (int i = 0; i < 130; i++)
      queue_cmd(make_cmd(REQ_ADVANCE, 0, 24'hFF_FFFF, 0, 0));
    queue_cmd(make_cmd(REQ_DEACTIVATE, 4, 0, 0, 0));

    // random: mostly arm-then-advance bursts, the rest unconstrained noise
    while (rand_cmds < 62) begin
      if ($urandom_range(0, 99) < 70) begin
        n_act = $urandom_range(1, 3);
        n_adv = $urandom_range(1, 4);
        for (int k = 0; k < n_act; k++) begin
          s = $urandom_range(0, NUM_SLOTS - 1);
          gen_live[s] = 1'b1;
          queue_cmd(make_cmd(REQ_ACTIVATE, s, 0,
                             longint'($urandom_range(0, 42000)) - 2000,
                             ($urandom_range(0, 49) == 0) ? 0 :
                             $urandom_range(1, 30000)));
        end
        for (int k = 0; k < n_adv; k++) begin
          dt = ($urandom_range(0, 9) == 0) ? longint'($urandom_range(0, 24'hFF_FFFF)) :
                                             longint'($urandom_range(0, 40000));
          queue_cmd(make_cmd(REQ_ADVANCE, 0, dt, 0, 0));
        end
        rand_cmds += n_act + n_adv;
        if (gen_live != 0 && $urandom_range(0, 99) < 40) begin
          do s = $urandom_range(0, NUM_SLOTS - 1); while (!gen_live[s]);
          gen_live[s] = 1'b0;
          queue_cmd(make_cmd(REQ_DEACTIVATE, s, 0, 0, 0));
          rand_cmds++;
        end
      end else begin
        dt = ($urandom_range(0, 19) == 0) ? longint'($urandom_range(0, 24'hFF_FFFF)) :
                                            longint'($urandom_range(0, 40000));
        c = make_cmd(2'($urandom), $urandom_range(0, NUM_SLOTS - 1), dt, $urandom,
                     $urandom);
        if (c.req_type == REQ_ACTIVATE) gen_live[c.slot] = 1'b1;
        if (c.req_type == REQ_DEACTIVATE) gen_live[c.slot] = 1'b0;
        queue_cmd(c);
        rand_cmds++;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (sched_cmds.size() != 0 || start || owed_reports.size() != 0);
    repeat (64) @(posedge clk);

    $display("Covered %0d items (%0d advances, %0d hitting the firing cap),",
             cmds_taken, advances, cap_hits);
    $display("%0d results, %0d firings, %0d ticks advanced, %0d firings saturated.",
             reports_seen, firings_seen, tick_total, clip_hits);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout waiting for the scheduler to drain");
    $display("Test completed with failures");
    $finish;
  end

endmodule
